### hw/rtl/i2pda_pkg.sv
// Shared types, constants and helper functions for the signed integer to
// padded decimal text unit. No dependencies.
`default_nettype none

package i2pda_pkg;

  localparam int unsigned VAL_W       = 32;  // width of the input value
  localparam int unsigned NUM_DIGITS  = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned CFG_W       = 4;   // widest configuration register
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] MAX_DIGITS   = 4'd10;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;

  // Configuration register indexes.
  localparam logic REG_MIN_DIGITS = 1'b0;
  localparam logic REG_PAD_SPACES = 1'b1;

  // One converted number waiting for character output.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Count of significant digits in a packed BCD word, at least one.
  function automatic logic [3:0] bcd_ndig(input logic [BCD_W-1:0] bcd);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  // One double-dabble step: add three to every digit of five or more.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      r[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/i2pda_front.sv
// Front end: takes a request, records the sign and converts the magnitude to
// BCD by shift-and-add-three, one bit per cycle. Depends on i2pda_pkg.
`default_nettype none

module i2pda_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [i2pda_pkg::VAL_W-1:0]  value_i,
  output logic                                busy_o,
  input  i2pda_pkg::q_stat_t                  q_stat_i,
  output logic                                push_o,
  output i2pda_pkg::entry_t                   push_data_o
);
  import i2pda_pkg::*;

  localparam int unsigned CntW = $clog2(VAL_W);

  typedef enum logic [2:0] {
    FR_IDLE = 3'b001,
    FR_CONV = 3'b010,
    FR_PUSH = 3'b100
  } fr_state_e;

  fr_state_e        state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [VAL_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] bcd_adj;
  logic [VAL_W-1:0] raw;

  assign raw     = VAL_W'(unsigned'(value_i));
  assign bcd_adj = bcd_adjust(bcd_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    push_o  = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (start_i) begin
          neg_d   = raw[VAL_W-1];
          // Two's complement negation also yields the most negative magnitude.
          bin_d   = raw[VAL_W-1] ? (VAL_W'(0) - raw) : raw;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FR_CONV;
        end
      end
      FR_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VAL_W-1]};
        bin_d = {bin_q[VAL_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(VAL_W - 1)) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o          = (state_q != FR_IDLE);
  assign push_data_o.neg = neg_q;
  assign push_data_o.bcd = bcd_q;

endmodule

`default_nettype wire

### hw/rtl/i2pda_fifo.sv
// Short register queue of converted numbers between the front and back ends.
// Depends on i2pda_pkg.
`default_nettype none

module i2pda_fifo #(
  parameter int unsigned Depth = i2pda_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2pda_pkg::entry_t  push_data_i,
  input  logic               pop_i,
  output i2pda_pkg::entry_t  pop_data_o,
  output i2pda_pkg::q_stat_t stat_o
);
  import i2pda_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/i2pda_back.sv
// Back end: takes one converted number from the queue and emits its sign,
// padding and digits one character per cycle. Depends on i2pda_pkg.
`default_nettype none

module i2pda_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         min_digits_i,
  input  logic               pad_spaces_i,
  input  i2pda_pkg::q_stat_t q_stat_i,
  input  i2pda_pkg::entry_t  pop_data_i,
  output logic               pop_o,
  output logic               char_valid_o,
  output logic [7:0]         text_char_o,
  output logic               last_char_o
);
  import i2pda_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EMIT = 2'b10
  } bk_state_e;

  bk_state_e        state_q, state_d;
  logic             sign_q, sign_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [3:0]       ndig_q, ndig_d;
  logic [3:0]       pos_q, pos_d;
  logic             valid_q, valid_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;
  logic [3:0]       head_ndig;
  logic [3:0]       idx;
  logic [3:0]       digit;

  assign head_ndig = bcd_ndig(pop_data_i.bcd);
  assign idx       = pos_q - 4'd1;
  assign digit     = bcd_q[{idx, 2'b00} +: 4];

  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    bcd_d   = bcd_q;
    ndig_d  = ndig_q;
    pos_d   = pos_q;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          sign_d  = pop_data_i.neg;
          bcd_d   = pop_data_i.bcd;
          ndig_d  = head_ndig;
          pos_d   = (min_digits_i > head_ndig) ? min_digits_i : head_ndig;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        valid_d = 1'b1;
        if (sign_q) begin
          // At least one digit always follows the sign.
          char_d = ASCII_MINUS;
          sign_d = 1'b0;
        end else begin
          if (pos_q > ndig_q) begin
            char_d = pad_spaces_i ? ASCII_SPACE : ASCII_ZERO;
          end else begin
            char_d = ASCII_ZERO | {4'h0, digit};
          end
          last_d = (pos_q == 4'd1);
          pos_d  = pos_q - 4'd1;
          if (pos_q == 4'd1) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
    pos_q  <= pos_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign char_valid_o = valid_q;
  assign text_char_o  = char_q;
  assign last_char_o  = last_q;

endmodule

`default_nettype wire

### hw/rtl/int32_to_padded_decimal_ascii_unit.sv
// Flow: the front end converts a request to BCD and hands it to the queue; the back end
// pops one number at a time and strobes its characters, one character per cycle.
// The converter takes no new request until it has pushed the last one (busy_o meanwhile,
// also while the queue is full); the character stage pops a number only when idle.
// Reset: asynchronous; empties the queue, min_digits 0, padding with '0'.
// Results cannot be stalled. Top level; depends on i2pda_pkg and the submodules.
`default_nettype none

module int32_to_padded_decimal_ascii_unit #(
  parameter int unsigned QueueDepth = i2pda_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [i2pda_pkg::VAL_W-1:0] value_i,
  output logic                               busy_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [i2pda_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                               char_valid_o,
  output logic [7:0]                         text_char_o,
  output logic                               last_char_o
);
  import i2pda_pkg::*;

  logic [3:0] min_dig_q;
  logic       pad_spaces_q;
  entry_t     push_data, pop_data;
  q_stat_t    q_stat;
  logic       push, pop;

  // Writes above ten are stored as ten.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dig_q    <= 4'd0;
      pad_spaces_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_DIGITS: min_dig_q <= (cfg_data_i > MAX_DIGITS) ? MAX_DIGITS : cfg_data_i;
        REG_PAD_SPACES: pad_spaces_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  i2pda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  i2pda_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  i2pda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_digits_i (min_dig_q),
    .pad_spaces_i (pad_spaces_q),
    .q_stat_i     (q_stat),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire

### hw/rtl/i2pda_chk.sv
// Port-level checker for the decimal text unit, bound to the top level.
// Depends on i2pda_pkg for the character codes.
`default_nettype none

module i2pda_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       char_valid_o,
  input logic [7:0] text_char_o,
  input logic       last_char_o
);
  import i2pda_pkg::*;

  // Every character is a minus sign, a space or a decimal digit.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (text_char_o == ASCII_MINUS) || (text_char_o == ASCII_SPACE) ||
                     ((text_char_o[7:4] == 4'h3) && (text_char_o[3:0] <= 4'd9)))
    else $error("character outside the decimal text set");

  // A minus sign never ends a number and is always followed by a character.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && (text_char_o == ASCII_MINUS)) |-> !last_char_o)
    else $error("minus sign flagged as last character");

  a_minus_then_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && (text_char_o == ASCII_MINUS)) |=>
      (char_valid_o && (text_char_o != ASCII_MINUS)))
    else $error("minus sign not followed by a padding or digit character");

  // An accepted request occupies the converter on the next cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("converter not busy after an accepted request");

endmodule

bind int32_to_padded_decimal_ascii_unit i2pda_chk u_i2pda_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .char_valid_o (char_valid_o),
  .text_char_o  (text_char_o),
  .last_char_o  (last_char_o)
);

`default_nettype wire

### tb/tb.sv
// Testbench for int32_to_padded_decimal_ascii_unit: sends signed values, predicts the
// padded decimal text of each and checks every character as it comes out.
// Depends on i2pda_pkg and the RTL of the unit.

module tb;
  import i2pda_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start_i    = 1'b0;
  logic signed [VAL_W-1:0] value_i    = '0;
  logic                    cfg_we_i   = 1'b0;
  logic                    cfg_idx_i  = REG_MIN_DIGITS;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    busy_o;
  logic                    char_valid_o;
  logic [7:0]              text_char_o;
  logic                    last_char_o;

  // Copy of the unit's registers and the characters still to come.
  logic [3:0]   min_digits_cfg = 4'd0;
  logic         pad_spaces_cfg = 1'b0;
  text_char_t   text_q[$];
  int unsigned  idle_pct       = 0;
  int unsigned  fail_cnt       = 0;
  int unsigned  quiet_cycles   = 0;

  int32_to_padded_decimal_ascii_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .char_valid_o(char_valid_o),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Appends the expected text of one value to text_q.
  function automatic void predict_text(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] mag;
    logic [3:0]       digs [NUM_DIGITS];
    logic [7:0]       pad_ch;
    logic             neg;
    int               ndig;
    int               width;
    text_char_t       c;
    neg = v[VAL_W-1];
    // The two's complement of the most negative value is its magnitude when unsigned.
    mag = neg ? (~v + 1'b1) : v;
    ndig = 0;
    do begin
      digs[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 0 && ndig < NUM_DIGITS);
    width = (int'(min_digits_cfg) > ndig) ? int'(min_digits_cfg) : ndig;
    if (width > NUM_DIGITS) begin
      width = NUM_DIGITS;
    end
    pad_ch = pad_spaces_cfg ? ASCII_SPACE : ASCII_ZERO;
    if (neg) begin
      c.ch = ASCII_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = width; i > 0; i--) begin
      c.ch = (i > ndig) ? pad_ch : ASCII_ZERO + 8'(digs[i-1]);
      c.last = (i == 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    longint                  lo;
    longint                  hi;
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // A value with a chosen number of digits.
        lo = 1;
        repeat ($urandom_range(0, 9)) lo *= 10;
        hi = lo * 10 - 1;
        if (hi > 64'sd2147483647) begin
          hi = 64'sd2147483647;
        end
        v = VAL_W'(lo + longint'($urandom) % (hi - lo + 1));
      end
      4, 5, 6: v = $urandom;
      7: v = $urandom_range(0, 20);
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        // Just around a power of ten.
        lo = 1;
        repeat ($urandom_range(0, 9)) lo *= 10;
        v = VAL_W'(lo + $urandom_range(0, 2) - 1);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_value(input logic signed [VAL_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_text(v);
  endtask

  task automatic wait_text_drained();
    start_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes both registers; only called while the unit is idle.
  task automatic configure(input logic [3:0] min_digits, input logic pad_spaces);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MIN_DIGITS;
    cfg_data_i <= min_digits;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PAD_SPACES;
    cfg_data_i <= {3'b000, pad_spaces};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    min_digits_cfg = (min_digits > MAX_DIGITS) ? MAX_DIGITS : min_digits;
    pad_spaces_cfg = pad_spaces;
  endtask

  task automatic test_reset_defaults();
    send_value(32'sd0);
    send_value(32'sd7);
    send_value(-32'sd1);
    wait_text_drained();
  endtask

  task automatic test_digit_count_clamp();
    configure(4'd15, 1'b0);
    send_value(32'sd0);
    send_value(-32'sd5);
    send_value(32'sh8000_0000);
    send_value(32'sh7fff_ffff);
    wait_text_drained();
    configure(4'd12, 1'b1);
    send_value(32'sd123);
    send_value(-32'sd123);
    wait_text_drained();
  endtask

  task automatic test_space_padding();
    configure(4'd4, 1'b1);
    send_value(32'sd0);
    send_value(-32'sd7);
    send_value(32'sd12345);
    wait_text_drained();
  endtask

  task automatic test_decade_edges();
    configure(4'd0, 1'b0);
    send_value(32'sd1000000000);
    send_value(-32'sd1000000000);
    send_value(32'sd999999999);
    send_value(32'sd9);
    send_value(32'sd10);
    send_value(-32'sd2147483647);
    wait_text_drained();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: configure(4'd0, 1'b0);
        1: configure(4'd10, 1'b1);
        2: configure(4'd15, 1'b0);
        default: configure(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      endcase
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 20;
      endcase
      repeat (45) send_value(random_value());
      wait_text_drained();
    end
    idle_pct = 0;
  endtask

  always @(posedge clk_i) begin : check_chars
    text_char_t exp_c;
    if (rst_ni && char_valid_o) begin
      if (text_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("unexpected character %h last %b", text_char_o, last_char_o);
        end
      end else begin
        exp_c = text_q.pop_front();
        if (text_char_o !== exp_c.ch || last_char_o !== exp_c.last) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("character mismatch: expected %h last %b, got %h last %b",
                     exp_c.ch, exp_c.last, text_char_o, last_char_o);
          end
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither a request nor a character is taken.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || char_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_digit_count_clamp();
    test_space_padding();
    test_decade_edges();
    test_random_traffic();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && text_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
